[hw/rtl/key_sequence_matcher_assert.svh]
// ----------------------------------------------------------------------------
// key_sequence_matcher_assert.svh
// Assertion macros used by the key sequence matcher checker.
// ----------------------------------------------------------------------------
`ifndef KEY_SEQUENCE_MATCHER_ASSERT_SVH
`define KEY_SEQUENCE_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSM_ASSERT_NOW(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KSM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

[hw/rtl/ksm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksm_pkg
// Types and constants shared by the key sequence matcher modules.
// ----------------------------------------------------------------------------
package ksm_pkg;

  localparam int CODE_W    = 16;
  localparam int ACT_W     = 8;
  localparam int TOK_SLOT_W = 8;   // holds any slot index up to 256 slots
  localparam int TOK_LEN_W  = 5;   // holds any sequence length up to 16 keys

  typedef enum logic [1:0] {
    OP_PRESS = 2'd0,
    OP_CODE  = 2'd1,
    OP_SEQ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  // One slot under test travelling down the compare chain.
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic                  alive;
    logic [TOK_SLOT_W-1:0] slot;
    logic [TOK_LEN_W-1:0]  len;
    logic [ACT_W-1:0]      action;
  } tok_t;

endpackage

[hw/rtl/ksm_slot_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksm_slot_table
// Per-slot length and action store; launches one slot token a cycle.
// ----------------------------------------------------------------------------
module ksm_slot_table #(
  parameter int MAX_KEYS  = 8,
  parameter int NUM_SLOTS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    wr_en,
  input  logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] wr_slot,
  input  logic [$clog2(MAX_KEYS+1)-1:0]           wr_len,
  input  logic [ksm_pkg::ACT_W-1:0]               wr_act,
  input  logic                                    iss_en,
  input  logic                                    iss_last,
  input  logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] iss_slot,
  output ksm_pkg::tok_t                           tok_out
);
  import ksm_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);

  logic [CNT_W-1:0]  len_mem [NUM_SLOTS];
  logic [ACT_W-1:0]  act_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_r;

  logic [CNT_W-1:0]  len_rd_r;
  logic [ACT_W-1:0]  act_rd_r;
  logic              vld_rd_r;
  logic              tok_vld_r;
  logic              tok_last_r;
  logic [SLOT_W-1:0] tok_slot_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      len_mem[wr_slot] <= wr_len;
      act_mem[wr_slot] <= wr_act;
    end
    len_rd_r   <= len_mem[iss_slot];
    act_rd_r   <= act_mem[iss_slot];
    tok_slot_r <= iss_slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      vld_rd_r   <= 1'b0;
      tok_vld_r  <= 1'b0;
      tok_last_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_slot] <= 1'b1;
      end
      vld_rd_r   <= vld_r[iss_slot];
      tok_vld_r  <= iss_en;
      tok_last_r <= iss_en & iss_last;
    end
  end

  // Slots never written read as empty.
  always_comb begin
    tok_out.valid  = tok_vld_r;
    tok_out.last   = tok_last_r;
    tok_out.alive  = 1'b1;
    tok_out.slot   = TOK_SLOT_W'(tok_slot_r);
    tok_out.len    = vld_rd_r ? TOK_LEN_W'(len_rd_r) : '0;
    tok_out.action = act_rd_r;
  end

endmodule

[hw/rtl/ksm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksm_cell
// One key position: buffered press, code column of all slots, one compare.
// ----------------------------------------------------------------------------
module ksm_cell #(
  parameter int MAX_KEYS  = 8,
  parameter int NUM_SLOTS = 32,
  parameter int CELL_IDX  = 0
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    wr_en,
  input  logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] wr_slot,
  input  logic [ksm_pkg::CODE_W-1:0]              wr_code,
  input  logic                                    push_en,
  input  logic [ksm_pkg::CODE_W-1:0]              push_code,
  input  logic [$clog2(MAX_KEYS+1)-1:0]           press_count,
  input  ksm_pkg::tok_t                           tok_in,
  output ksm_pkg::tok_t                           tok_out
);
  import ksm_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);

  logic [CODE_W-1:0] code_mem [NUM_SLOTS];
  logic [CODE_W-1:0] rd_r;
  logic [CODE_W-1:0] key_r;
  tok_t              tok_r;
  logic              beyond;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[wr_slot] <= wr_code;
    end
    rd_r <= code_mem[tok_in.slot[SLOT_W-1:0]];
    if (push_en) begin
      key_r <= push_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
  end

  // Positions past the buffered count do not take part in the compare.
  assign beyond = (CNT_W'(CELL_IDX) >= press_count);

  always_comb begin
    tok_out       = tok_r;
    tok_out.alive = tok_r.alive & (beyond | (rd_r == key_r));
  end

endmodule

[hw/rtl/key_sequence_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_sequence_matcher
// Matches key presses against a table of multi-key shortcut sequences.
// ----------------------------------------------------------------------------
// A load item (code write or length/action write) leaves the input ready. A key
// press holds the input while every slot is scanned when it only extends a
// prefix, and through the emit state as well when it emits a result.
// That result shows on out_tvalid at the same edge the input is ready again.
// Every slot is launched in order, one per cycle, into a row of MAX_KEYS
// compare cells, one cell per key position. The first slot that matches the
// buffer as an exact sequence or as a proper prefix decides the result once the
// last slot has left the row. Input is taken only between items; a finished
// result sits in the output register while the next item is accepted, and a
// press that ends while that register is still stalled waits for it to drain.
module key_sequence_matcher #(
  parameter int MAX_KEYS    = 8,
  parameter int NUM_SLOTS   = 32,
  parameter int NUM_ACTIONS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] key_code, [20:16] slot_index, [23:21] position,
  // [27:24] seq_length, [35:28] action_id, [39:36] zero
  input  logic [39:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] action_out, [23:8] char_out
  output logic [23:0] out_tdata,
  // [0] result_kind
  output logic [0:0]  out_tuser
);
  import ksm_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);

  // Input unpack
  op_t               op;
  logic [CODE_W-1:0] in_code;
  logic [4:0]        in_slot;
  logic [2:0]        in_pos;
  logic [3:0]        in_len;
  logic [ACT_W-1:0]  in_act;

  assign op      = op_t'(in_tuser);
  assign in_code = in_tdata[15:0];
  assign in_slot = in_tdata[20:16];
  assign in_pos  = in_tdata[23:21];
  assign in_len  = in_tdata[27:24];
  assign in_act  = in_tdata[35:28];

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] iss_r;
  logic              iss_on_r;
  logic [CODE_W-1:0] code_r;
  logic              found_r;
  logic              exact_r;
  logic [ACT_W-1:0]  fact_r;
  logic              pkind_r;
  logic [ACT_W-1:0]  pact_r;
  logic [CODE_W-1:0] pchar_r;
  logic              out_vld_r;
  logic [23:0]       out_data_r;
  logic              out_kind_r;

  logic              acc;
  logic              press_acc;
  logic              slot_ok;
  logic [CNT_W-1:0]  push_idx;
  logic              seq_wr;
  logic [SLOT_W-1:0] wr_slot;
  logic [CNT_W-1:0]  sat_len;
  logic [ACT_W-1:0]  sat_act;
  logic              iss_last;
  logic              out_load;
  logic              dec;
  logic              dec_exact;
  logic              fin;
  logic              fin_found;
  logic              fin_exact;
  logic [ACT_W-1:0]  fin_act;

  tok_t tok [MAX_KEYS+1];
  tok_t tail;

  assign acc       = in_tvalid & in_tready;
  assign press_acc = acc & (op == OP_PRESS);
  assign slot_ok   = (int'(in_slot) < NUM_SLOTS);
  assign wr_slot   = SLOT_W'(in_slot);
  assign push_idx  = (int'(cnt_r) >= MAX_KEYS) ? '0 : cnt_r;
  assign seq_wr    = acc & (op == OP_SEQ) & slot_ok;
  assign sat_len   = (int'(in_len) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : CNT_W'(in_len);
  assign sat_act   = (int'(in_act) >= NUM_ACTIONS) ? ACT_W'(NUM_ACTIONS - 1) : in_act;
  assign iss_last  = (int'(iss_r) == NUM_SLOTS - 1);

  ksm_slot_table #(
    .MAX_KEYS  (MAX_KEYS),
    .NUM_SLOTS (NUM_SLOTS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (seq_wr),
    .wr_slot  (wr_slot),
    .wr_len   (sat_len),
    .wr_act   (sat_act),
    .iss_en   (iss_on_r),
    .iss_last (iss_last),
    .iss_slot (iss_r),
    .tok_out  (tok[0])
  );

  for (genvar k = 0; k < MAX_KEYS; k++) begin : g_cell
    logic code_wr;
    logic push_en;

    assign code_wr = acc & (op == OP_CODE) & slot_ok & (int'(in_pos) == k);
    assign push_en = press_acc & (int'(push_idx) == k);

    ksm_cell #(
      .MAX_KEYS  (MAX_KEYS),
      .NUM_SLOTS (NUM_SLOTS),
      .CELL_IDX  (k)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .wr_en       (code_wr),
      .wr_slot     (wr_slot),
      .wr_code     (in_code),
      .push_en     (push_en),
      .push_code   (in_code),
      .press_count (cnt_r),
      .tok_in      (tok[k]),
      .tok_out     (tok[k+1])
    );
  end

  assign tail = tok[MAX_KEYS];

  // Slot decision at the end of the row
  always_comb begin
    dec       = tail.valid & tail.alive & (tail.len != '0) &
                (tail.len >= TOK_LEN_W'(cnt_r));
    dec_exact = (tail.len == TOK_LEN_W'(cnt_r));
    fin       = (state_r == ST_SCAN) & tail.valid & tail.last;
    fin_found = found_r | dec;
    fin_exact = found_r ? exact_r : dec_exact;
    fin_act   = found_r ? fact_r : tail.action;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (press_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (fin) begin
          state_nxt = (fin_found & ~fin_exact) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_vld_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_SCAN: ;
      ST_EMIT: out_load = ~out_vld_r | out_tready;
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (press_acc) begin
      cnt_nxt = push_idx + CNT_W'(1);
    end else if (fin && !(fin_found && !fin_exact)) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      iss_on_r  <= 1'b0;
      iss_r     <= '0;
      found_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (press_acc) begin
        iss_on_r <= 1'b1;
        iss_r    <= '0;
        found_r  <= 1'b0;
      end else if (iss_on_r) begin
        if (iss_last) begin
          iss_on_r <= 1'b0;
        end else begin
          iss_r <= iss_r + SLOT_W'(1);
        end
      end
      if (state_r == ST_SCAN && dec && !found_r) begin
        found_r <= 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (press_acc) begin
      code_r <= in_code;
    end
    if (state_r == ST_SCAN && dec && !found_r) begin
      exact_r <= dec_exact;
      fact_r  <= tail.action;
    end
    if (fin) begin
      pkind_r <= ~fin_found;
      pact_r  <= fin_found ? fin_act : '0;
      pchar_r <= fin_found ? '0 : code_r;
    end
    if (out_load) begin
      out_kind_r <= pkind_r;
      out_data_r <= {pchar_r, pact_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

[hw/rtl/ksm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksm_checker
// Port-level checks on the key sequence matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "key_sequence_matcher_assert.svh"

module ksm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [0:0]  out_tuser
);
  import ksm_pkg::*;

  logic press_acc;
  logic load_acc;

  assign press_acc = in_tvalid & in_tready & (in_tuser == OP_PRESS);
  assign load_acc  = in_tvalid & in_tready &
                     ((in_tuser == OP_CODE) || (in_tuser == OP_SEQ));

  // A press always starts a scan and drops the input ready.
  `KSM_ASSERT_NEXT(a_press_busy, clk, rst_n, press_acc, !in_tready, "press did not start a scan")

  // Table loads do not hold the input.
  `KSM_ASSERT_NEXT(a_load_quick, clk, rst_n, load_acc, in_tready, "load held the input")

  // An action carries no character, a character carries no action.
  `KSM_ASSERT_NOW(a_kind_fields, clk, rst_n, out_tvalid,
    (out_tuser[0] ? (out_tdata[7:0] == 8'd0) : (out_tdata[23:8] == 16'd0)),
    "result field not cleared for its kind")

  // Stalled item holds.
  `KSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled item changed")

endmodule

bind key_sequence_matcher ksm_checker u_ksm_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Loads shortcut sequences into key_sequence_matcher and feeds it key presses.
// A scoreboard mirrors the table and the press buffer, predicts every emitted
// action or plain character, and checks each result in order. The run covers
// free-running traffic, a slow sender, a stalling receiver and light idling.
// ----------------------------------------------------------------------------
module testbench;
  import ksm_pkg::*;

  localparam int MAX_KEYS      = 8;
  localparam int NUM_SLOTS     = 32;
  localparam int NUM_ACTIONS   = 256;
  localparam int RANDOM_ITEMS  = 600;
  localparam int SETTLE_CYCLES = 100;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic       KIND_ACTION = 1'b0;
  localparam logic       KIND_CHAR   = 1'b1;

  typedef logic [CODE_W-1:0] key_t;
  typedef key_t key_row_t [MAX_KEYS];

  typedef struct packed {
    logic              kind;
    logic [ACT_W-1:0]  action;
    logic [CODE_W-1:0] ch;
  } emit_t;

  class shortcut_tracker;
    key_t              press_keys[MAX_KEYS];
    int unsigned       press_depth;
    key_t              slot_keys[NUM_SLOTS][MAX_KEYS];
    bit [MAX_KEYS-1:0] key_written[NUM_SLOTS];
    int unsigned       slot_len[NUM_SLOTS];
    logic [ACT_W-1:0]  slot_action[NUM_SLOTS];
    emit_t             pending_emits[$];
    int unsigned       errors;

    function void apply_item(logic [1:0] op, logic [39:0] data);
      key_t        code;
      int unsigned slot, pos, len, act, s, i;
      emit_t       e;
      code = data[15:0];
      slot = data[20:16];
      pos  = data[23:21];
      len  = data[27:24];
      act  = data[35:28];
      case (op)
        OP_PRESS: begin
          if (press_depth >= MAX_KEYS) press_depth = 0;
          press_keys[press_depth] = code;
          press_depth++;
          for (s = 0; s < NUM_SLOTS; s++) begin
            if (slot_len[s] == 0 || slot_len[s] < press_depth) continue;
            for (i = 0; i < press_depth; i++)
              if (press_keys[i] != slot_keys[s][i]) break;
            // a diverged partial match decides nothing
            if (i != press_depth) continue;
            if (slot_len[s] == press_depth) begin
              press_depth = 0;
              e.kind   = KIND_ACTION;
              e.action = slot_action[s];
              e.ch     = '0;
              pending_emits.push_back(e);
            end
            return;
          end
          press_depth = 0;
          e.kind   = KIND_CHAR;
          e.action = '0;
          e.ch     = code;
          pending_emits.push_back(e);
        end
        OP_CODE: begin
          if (slot < NUM_SLOTS && pos < MAX_KEYS) begin
            slot_keys[slot][pos]   = code;
            key_written[slot][pos] = 1'b1;
          end
        end
        OP_SEQ: begin
          if (slot < NUM_SLOTS) begin
            slot_len[slot]    = (len > MAX_KEYS) ? MAX_KEYS : len;
            slot_action[slot] = (act >= NUM_ACTIONS) ? ACT_W'(NUM_ACTIONS - 1) : ACT_W'(act);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_emit(logic kind, logic [23:0] data);
      emit_t want;
      if (pending_emits.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: kind %0d action %h char %h",
                 $time, kind, data[7:0], data[23:8]);
        return;
      end
      want = pending_emits.pop_front();
      if (kind !== want.kind) begin
        errors++;
        $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, kind);
      end
      if (data[7:0] !== want.action) begin
        errors++;
        $display("%0t: action_out expected %h actual %h", $time, want.action, data[7:0]);
      end
      if (data[23:8] !== want.ch) begin
        errors++;
        $display("%0t: char_out expected %h actual %h", $time, want.ch, data[23:8]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;

  shortcut_tracker tracker;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int items_sent     = 0;

  key_sequence_matcher #(
    .MAX_KEYS(MAX_KEYS),
    .NUM_SLOTS(NUM_SLOTS),
    .NUM_ACTIONS(NUM_ACTIONS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_emit(out_tuser[0], out_tdata);
  end

  function automatic logic [39:0] pack_item(key_t code, int slot, int pos, int len, int act);
    return {4'b0, 8'(act), 4'(len), 3'(pos), 5'(slot), code};
  endfunction

  function automatic key_t pick_key();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return key_t'(16'h0041 + $urandom_range(5));
      5:             return 16'h0000;
      6:             return 16'hFFFF;
      default:       return key_t'($urandom);
    endcase
  endfunction

  // hold the item until accepted; ends on the accepting edge
  task automatic send_item(input logic [1:0] op, input logic [39:0] data);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.apply_item(op, data);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic press_key(input key_t code);
    send_item(OP_PRESS, pack_item(code, $urandom_range(31), $urandom_range(7),
                                  $urandom_range(15), $urandom_range(255)));
  endtask

  // write the codes a length needs before the length itself
  task automatic load_slot(input int slot, input key_row_t keys, input int len_field,
                           input int act);
    int n;
    n = (len_field > MAX_KEYS) ? MAX_KEYS : len_field;
    for (int p = 0; p < n; p++)
      send_item(OP_CODE, pack_item(keys[p], slot, p, $urandom_range(15), $urandom_range(255)));
    send_item(OP_SEQ, pack_item(pick_key(), slot, $urandom_range(7), len_field, act));
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.pending_emits.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input int count);
    key_row_t          keys;
    int                live[$];
    int                stop, pick, s, n, cut, share, len_field;
    bit [MAX_KEYS-1:0] need;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // replay a stored sequence, sometimes breaking off with a stray key
        live.delete();
        for (int i = 0; i < NUM_SLOTS; i++)
          if (tracker.slot_len[i] != 0) live.push_back(i);
        if (live.size() == 0) begin
          press_key(pick_key());
        end else begin
          s   = live[$urandom_range(live.size() - 1)];
          n   = tracker.slot_len[s];
          cut = ($urandom_range(3) == 0) ? $urandom_range(n - 1) : n;
          for (int p = 0; p < n; p++) begin
            if (p == cut) begin
              press_key(pick_key());
              break;
            end
            press_key(tracker.slot_keys[s][p]);
          end
        end
      end else if (pick < 70) begin
        press_key(pick_key());
      end else if (pick < 88) begin
        // new sequence, often sharing a leading part with another slot
        len_field = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1, MAX_KEYS);
        for (int p = 0; p < MAX_KEYS; p++) keys[p] = pick_key();
        s = $urandom_range(NUM_SLOTS - 1);
        if (tracker.slot_len[s] != 0 && $urandom_range(1) == 1) begin
          share = $urandom_range(tracker.slot_len[s]);
          for (int p = 0; p < share; p++) keys[p] = tracker.slot_keys[s][p];
        end
        load_slot($urandom_range(NUM_SLOTS - 1), keys, len_field, $urandom_range(NUM_ACTIONS - 1));
      end else if (pick < 93) begin
        send_item(OP_CODE, pack_item(pick_key(), $urandom_range(NUM_SLOTS - 1),
                                     $urandom_range(MAX_KEYS - 1), $urandom_range(15),
                                     $urandom_range(255)));
      end else if (pick < 97) begin
        // rewrite a length only where its codes are already in place
        s         = $urandom_range(NUM_SLOTS - 1);
        len_field = $urandom_range(15);
        n         = (len_field > MAX_KEYS) ? MAX_KEYS : len_field;
        need      = '0;
        for (int p = 0; p < n; p++) need[p] = 1'b1;
        if ((tracker.key_written[s] & need) == need)
          send_item(OP_SEQ, pack_item(pick_key(), s, $urandom_range(7), len_field,
                                      $urandom_range(255)));
      end else begin
        send_item(OP_UNUSED, pack_item(key_t'($urandom), $urandom_range(31),
                                       $urandom_range(7), $urandom_range(15),
                                       $urandom_range(255)));
      end
    end
    drain();
  endtask

  initial begin
    tracker   = new;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_PRESS;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table: every press comes back as a plain character
    press_key(16'hFFFF);
    press_key(16'h0000);
    send_item(OP_UNUSED, pack_item(16'h1234, 5, 2, 3, 7));
    load_slot(0, '{0: 16'h0041, 1: 16'h0042, 2: 16'h0043, default: 16'h0000}, 3, 8'h11);
    load_slot(1, '{0: 16'h0041, 1: 16'h0044, default: 16'h0000}, 2, 8'hFF);
    // slot 0 matches only the first key, slot 1 then matches exactly
    press_key(16'h0041);
    press_key(16'h0044);
    press_key(16'h0041);
    press_key(16'h0042);
    press_key(16'h0043);
    // prefix that then fails everywhere
    press_key(16'h0041);
    press_key(16'h0045);
    load_slot(0, '{default: 16'h0000}, 0, 8'h22);
    press_key(16'h0041);
    press_key(16'h0042);
    load_slot(2, '{default: 16'h0000}, 1, 8'h00);
    press_key(16'h0000);
    drain();

    run_phase(0, 0, RANDOM_ITEMS / 4);
    run_phase(85, 0, RANDOM_ITEMS / 4);
    run_phase(0, 85, RANDOM_ITEMS / 4);
    run_phase(12, 12, RANDOM_ITEMS / 4);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ksm_pkg.sv
hw/rtl/ksm_slot_table.sv
hw/rtl/ksm_cell.sv
hw/rtl/key_sequence_matcher.sv
hw/rtl/ksm_checker.sv
verif/testbench.sv
